### rtl/isrch_pkg.sv
// ----------------------------------------------------------------------------
// Interpolation search package
// Field widths, operation codes and reset values shared by the block.
// ----------------------------------------------------------------------------
package isrch_pkg;

    localparam int KEY_W  = 32;   // table entry and key width
    localparam int IDX_W  = 10;   // entry index and result position width
    localparam int SIZE_W = 11;   // table size register width

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1);

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

endpackage

### rtl/isrch_req_if.sv
// ----------------------------------------------------------------------------
// Interpolation search request channel
// Valid/ready channel carrying one write or search request.
// ----------------------------------------------------------------------------
interface isrch_req_if;
    import isrch_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    op;
    logic [IDX_W-1:0]        entry_index;
    logic signed [KEY_W-1:0] entry_value;
    logic signed [KEY_W-1:0] search_key;

    modport source (output valid, op, entry_index, entry_value, search_key, input ready);
    modport sink   (input valid, op, entry_index, entry_value, search_key, output ready);
endinterface

### rtl/isrch_rsp_if.sv
// ----------------------------------------------------------------------------
// Interpolation search response channel
// Valid/ready channel carrying the found flag and position.
// ----------------------------------------------------------------------------
interface isrch_rsp_if;
    import isrch_pkg::*;

    logic             valid;
    logic             ready;
    logic             found;
    logic [IDX_W-1:0] position;

    modport source (output valid, found, position, input ready);
    modport sink   (input valid, found, position, output ready);
endinterface

### rtl/isrch_cfg_if.sv
// ----------------------------------------------------------------------------
// Interpolation search configuration channel
// Valid/ready write channel for the table size register.
// ----------------------------------------------------------------------------
interface isrch_cfg_if;
    import isrch_pkg::*;

    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] table_size;

    modport source (output valid, table_size, input ready);
    modport sink   (input valid, table_size, output ready);
endinterface

### rtl/isrch_table.sv
// ----------------------------------------------------------------------------
// Interpolation search table
// Single-port-write, single-port-read synchronous memory with a registered read.
// ----------------------------------------------------------------------------
module isrch_table #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [AW-1:0]                     i_waddr,
    input  logic signed [isrch_pkg::KEY_W-1:0] i_wdata,
    input  logic [AW-1:0]                     i_raddr,
    output logic signed [isrch_pkg::KEY_W-1:0] o_rdata
);
    import isrch_pkg::*;

    logic signed [KEY_W-1:0] r_mem [DEPTH];
    logic signed [KEY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/isrch_div.sv
// ----------------------------------------------------------------------------
// Interpolation search divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module isrch_div #(
    parameter int NW = 42
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [NW-1:0]                i_num,
    input  logic [isrch_pkg::KEY_W-1:0]  i_den,
    output logic                         o_done,
    output logic [NW-1:0]                o_quo
);
    import isrch_pkg::*;

    localparam int CW = $clog2(NW + 1);

    logic [KEY_W:0]   r_rem;
    logic [NW-1:0]    r_quo;
    logic [KEY_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [KEY_W:0]   shifted;
    logic             fits;

    assign shifted = {r_rem[KEY_W-1:0], r_quo[NW-1]};
    assign fits    = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? shifted - {1'b0, r_den} : shifted;
            r_quo <= {r_quo[NW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

### rtl/interpolation_search.sv
// ----------------------------------------------------------------------------
// Interpolation search
// Sorted table of signed entries with an interpolation search engine.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries write requests (op 0: store entry_value at entry_index)
//   and search requests (op 1: look for search_key in the first
//   table_size entries). A search gives one response on o_rsp with found
//   and position; a write gives none. i_cfg writes table_size and is
//   always ready; write it only while the block is idle.
// Operation:
//   A write is stored when it is taken. A search probe reads both bounds,
//   checks the key against them, multiplies and waits on the serial
//   divider, then reads and compares the probed entry; a probe where both
//   bounds hold the same value skips the divider. The response register
//   is loaded last. One request is worked on at a time.
// Reset:
//   table_size returns to 1. The table contents are not cleared; entries
//   must be written before a search reads them.
// Stall:
//   The response waits in an output register. Requests are still taken
//   meanwhile; a finished search holds until the register frees.
// ----------------------------------------------------------------------------
module interpolation_search #(
    parameter int DEPTH = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    isrch_req_if.sink   i_req,
    isrch_rsp_if.source o_rsp,
    isrch_cfg_if.sink   i_cfg
);
    import isrch_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = AW + 2;
    localparam int NW = KEY_W + AW;

    typedef enum logic [3:0] {
        S_IDLE, S_RLO, S_RHI, S_CHK, S_MUL, S_DIVGO, S_DIV, S_RMID, S_CMP, S_DONE
    } t_state;

    t_state                  r_state;
    logic [SIZE_W-1:0]       r_size;
    logic signed [LW-1:0]    r_lo, r_hi, r_mid;
    logic signed [KEY_W-1:0] r_key, r_alo;
    logic [KEY_W-1:0]        r_diff, r_den;
    logic [AW-1:0]           r_span;
    logic [NW-1:0]           r_num;
    logic                    r_hit;
    logic                    r_out_valid, r_out_found;
    logic [IDX_W-1:0]        r_out_pos;

    logic signed [KEY_W-1:0] rdata;
    logic [AW-1:0]           raddr;
    logic                    div_done;
    logic [NW-1:0]           div_quo;
    logic [31:0]             size_w, widx, mid_ext;
    logic                    req_fire, mem_we;
    logic signed [LW-1:0]    n_lo, n_hi;

    assign req_fire = i_req.valid && i_req.ready;
    assign widx     = 32'(i_req.entry_index);
    assign mem_we   = req_fire && (i_req.op == OP_WRITE) && (widx < 32'(DEPTH));
    assign size_w   = (32'(r_size) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(r_size);
    assign mid_ext  = 32'(r_mid[AW-1:0]);

    always_comb begin
        unique case (r_state)
            S_RHI:   raddr = r_hi[AW-1:0];
            S_RMID:  raddr = r_mid[AW-1:0];
            default: raddr = r_lo[AW-1:0];
        endcase
    end

    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (rdata < r_key) begin
            n_lo = r_mid + LW'(1);
        end else if (rdata > r_key) begin
            n_hi = r_mid - LW'(1);
        end
    end

    isrch_table #(.DEPTH(DEPTH), .AW(AW)) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (widx[AW-1:0]),
        .i_wdata (i_req.entry_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    isrch_div #(.NW(NW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIVGO),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_size      <= SIZE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_size <= i_cfg.table_size;
            end
            if (o_rsp.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (req_fire && i_req.op == OP_SEARCH) begin
                        r_key <= i_req.search_key;
                        r_lo  <= '0;
                        r_hi  <= LW'(size_w) - LW'(1);
                        r_hit <= 1'b0;
                        r_state <= (size_w == 32'd0) ? S_DONE : S_RLO;
                    end
                end
                S_RLO: r_state <= S_RHI;
                S_RHI: begin
                    r_alo   <= rdata;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_key < r_alo || r_key > rdata) begin
                        r_state <= S_DONE;
                    end else if (rdata == r_alo) begin
                        r_mid   <= r_lo;
                        r_state <= S_RMID;
                    end else begin
                        r_diff  <= KEY_W'(r_key - r_alo);
                        r_den   <= KEY_W'(rdata - r_alo);
                        r_span  <= AW'(r_hi - r_lo);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_num   <= NW'(r_diff) * NW'(r_span);
                    r_state <= S_DIVGO;
                end
                S_DIVGO: r_state <= S_DIV;
                S_DIV: begin
                    if (div_done) begin
                        r_mid   <= r_lo + LW'(div_quo[AW-1:0]);
                        r_state <= S_RMID;
                    end
                end
                S_RMID: r_state <= S_CMP;
                S_CMP: begin
                    r_lo <= n_lo;
                    r_hi <= n_hi;
                    if (rdata == r_key) begin
                        r_hit   <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= (n_lo <= n_hi) ? S_RLO : S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the response register is free
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_found <= r_hit;
                        r_out_pos   <= r_hit ? mid_ext[IDX_W-1:0] : '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready    = (r_state == S_IDLE);
    assign i_cfg.ready    = 1'b1;
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.found    = r_out_found;
    assign o_rsp.position = r_out_pos;

    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.found |-> o_rsp.position == '0)
        else $error("miss response with nonzero position");

    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CMP |-> (r_mid >= r_lo) && (r_mid <= r_hi))
        else $error("probe outside search bounds");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !i_req.ready)
        else $error("request taken while search in progress");

    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIVGO |=> r_state == S_DIV)
        else $error("divider start not followed by wait");
endmodule
